// ===== src/swrc_pkg.sv =====
// shared constants for the sliding window range counter
package swrc_pkg;

  // default number of cells in the sample chain
  localparam int unsigned DEF_MAX_WINDOW  = 64;
  // default sample width
  localparam int unsigned DEF_SAMPLE_BITS = 32;
  // width of the window size register
  localparam int unsigned CFG_BITS        = 7;
  // width of the hit counter
  localparam int unsigned COUNT_BITS      = 32;
  // window size after reset
  localparam logic [CFG_BITS-1:0] WSIZE_RESET = CFG_BITS'(1);

endpackage

// ===== src/swrc_in_if.sv =====
// sample input channel of the range counter
interface swrc_in_if #(
  parameter int unsigned SAMPLE_BITS = swrc_pkg::DEF_SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// ===== src/swrc_out_if.sv =====
// result output channel of the range counter
interface swrc_out_if #(
  parameter int unsigned SAMPLE_BITS = swrc_pkg::DEF_SAMPLE_BITS
) ();
  logic                               valid;
  logic                               ready;
  logic                               window_full;
  logic signed [SAMPLE_BITS-1:0]      window_min;
  logic signed [SAMPLE_BITS-1:0]      window_max;
  logic                               hit;
  logic [swrc_pkg::COUNT_BITS-1:0]    hit_count;
  logic                               end_of_run;

  modport source (
    output valid, output window_full, output window_min, output window_max,
    output hit, output hit_count, output end_of_run, input ready
  );
  modport sink (
    input valid, input window_full, input window_min, input window_max,
    input hit, input hit_count, input end_of_run, output ready
  );
endinterface

// ===== src/swrc_cell.sv =====
// one cell of the sample chain: holds a sample and folds it into the passing min/max wave
module swrc_cell #(
  parameter int unsigned SAMPLE_BITS = swrc_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned WSIZE_BITS  = 7,
  parameter int unsigned INDEX       = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  input  logic [WSIZE_BITS-1:0]         wsize_i,
  input  logic                          wave_vld_i,
  input  logic signed [SAMPLE_BITS-1:0] wave_min_i,
  input  logic signed [SAMPLE_BITS-1:0] wave_max_i,
  output logic                          wave_vld_o,
  output logic signed [SAMPLE_BITS-1:0] wave_min_o,
  output logic signed [SAMPLE_BITS-1:0] wave_max_o
);

  localparam logic [WSIZE_BITS-1:0] Idx = WSIZE_BITS'(INDEX);

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          wave_vld_q;
  logic signed [SAMPLE_BITS-1:0] wave_min_q, wave_min_d;
  logic signed [SAMPLE_BITS-1:0] wave_max_q, wave_max_d;
  logic                          in_window;

  // this cell counts only while it lies inside the window
  assign in_window = (Idx < wsize_i);

  always_comb begin
    wave_min_d = wave_min_i;
    wave_max_d = wave_max_i;
    if (in_window) begin
      if (sample_q < wave_min_i) wave_min_d = sample_q;
      if (sample_q > wave_max_i) wave_max_d = sample_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) sample_q <= sample_i;
    wave_min_q <= wave_min_d;
    wave_max_q <= wave_max_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_vld_q <= 1'b0;
    end else begin
      wave_vld_q <= wave_vld_i;
    end
  end

  assign sample_o   = sample_q;
  assign wave_vld_o = wave_vld_q;
  assign wave_min_o = wave_min_q;
  assign wave_max_o = wave_max_q;

endmodule

// ===== src/sliding_window_range_counter.sv =====
// the result of an input beat is set by the min/max wave walking the cell chain one cell per
// cycle; one sample is in work at a time, so the next sample is taken only once the previous
// result has moved into the output register
// a result waiting in the output register does not block the next sample
// reset (async, active low) clears control, fill level, hit count and sets window size to 1;
// stored samples are not cleared, the fill level keeps unfilled cells out of the window
module sliding_window_range_counter #(
  parameter int unsigned MAX_WINDOW  = swrc_pkg::DEF_MAX_WINDOW,
  parameter int unsigned SAMPLE_BITS = swrc_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swrc_pkg::CFG_BITS-1:0] cfg_wdata_i,
  swrc_in_if.sink                       in_i,
  swrc_out_if.source                    out_o
);

  // width that holds 0..MAX_WINDOW
  localparam int unsigned WW = $clog2(MAX_WINDOW + 1);
  // common width for clamping the register value
  localparam int unsigned CW = (WW > swrc_pkg::CFG_BITS) ? WW : swrc_pkg::CFG_BITS;
  // width for comparing the span against the window size
  localparam int unsigned DW = ((SAMPLE_BITS + 1) > WW) ? (SAMPLE_BITS + 1) : WW;
  localparam int unsigned CB = swrc_pkg::COUNT_BITS;

  // wave seeds: neutral elements for min and max
  localparam logic signed [SAMPLE_BITS-1:0] SeedMin = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SeedMax = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAVE,
    S_HOLD
  } state_e;

  state_e                        state_q;
  logic                          start_q;
  logic [swrc_pkg::CFG_BITS-1:0] wsize_q;
  logic [WW-1:0]                 fill_q;
  logic [CB-1:0]                 cnt_q;
  logic                          last_q;
  logic signed [SAMPLE_BITS-1:0] mn_q, mx_q;

  // output register
  logic                          out_vld_q;
  logic                          out_full_q;
  logic signed [SAMPLE_BITS-1:0] out_min_q, out_max_q;
  logic                          out_hit_q;
  logic [CB-1:0]                 out_cnt_q;
  logic                          out_eor_q;

  logic          accept;
  logic          out_free;
  logic          load;
  logic [CW-1:0] ws_ext;
  logic [WW-1:0] w_eff;
  logic          full;
  logic [DW-1:0] span;
  logic [DW-1:0] w_m1;
  logic          hit;
  logic [CB-1:0] cnt_nxt;

  // chain wiring: samples shift towards higher cells, the wave follows behind
  logic signed [SAMPLE_BITS-1:0] smp      [MAX_WINDOW-1];
  logic                          wave_vld [MAX_WINDOW+1];
  logic signed [SAMPLE_BITS-1:0] wave_min [MAX_WINDOW+1];
  logic signed [SAMPLE_BITS-1:0] wave_max [MAX_WINDOW+1];

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;
  assign load     = (state_q == S_HOLD) && out_free;

  assign in_i.ready = (state_q == S_IDLE);

  // window size zero acts as one, above the chain length it is clamped
  always_comb begin
    ws_ext = CW'(wsize_q);
    if (ws_ext == '0) begin
      w_eff = WW'(1);
    end else if (ws_ext > CW'(MAX_WINDOW)) begin
      w_eff = WW'(MAX_WINDOW);
    end else begin
      w_eff = WW'(ws_ext);
    end
  end

  // the wave enters cell 0 the cycle after the new sample lands there
  assign wave_vld[0] = start_q;
  assign wave_min[0] = SeedMin;
  assign wave_max[0] = SeedMax;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] s_in;
    logic signed [SAMPLE_BITS-1:0] s_out;

    if (k == 0) begin : g_head
      assign s_in = in_i.sample;
    end else begin : g_body
      assign s_in = smp[k-1];
    end

    if (k < MAX_WINDOW - 1) begin : g_link
      assign smp[k] = s_out;
    end

    swrc_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .WSIZE_BITS  (WW),
      .INDEX       (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (accept),
      .sample_i   (s_in),
      .sample_o   (s_out),
      .wsize_i    (w_eff),
      .wave_vld_i (wave_vld[k]),
      .wave_min_i (wave_min[k]),
      .wave_max_i (wave_max[k]),
      .wave_vld_o (wave_vld[k+1]),
      .wave_min_o (wave_min[k+1]),
      .wave_max_o (wave_max[k+1])
    );
  end

  // result evaluation on the captured min and max
  assign full    = (fill_q >= w_eff);
  assign span    = DW'({mx_q[SAMPLE_BITS-1], mx_q} - {mn_q[SAMPLE_BITS-1], mn_q});
  assign w_m1    = DW'(w_eff - WW'(1));
  assign hit     = full && (span == w_m1);
  assign cnt_nxt = (hit && (cnt_q != '1)) ? cnt_q + CB'(1) : cnt_q;

  // control state, window size, fill level, hit count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      start_q   <= 1'b0;
      wsize_q   <= swrc_pkg::WSIZE_RESET;
      fill_q    <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      start_q <= accept;
      if (cfg_we_i) wsize_q <= cfg_wdata_i;

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_WAVE;
            if (fill_q != WW'(MAX_WINDOW)) fill_q <= fill_q + WW'(1);
          end
        end
        S_WAVE: begin
          if (wave_vld[MAX_WINDOW]) state_q <= S_HOLD;
        end
        S_HOLD: begin
          if (out_free) begin
            state_q <= S_IDLE;
            // the last beat of a sequence starts the next one afresh
            fill_q  <= last_q ? '0 : fill_q;
            cnt_q   <= last_q ? '0 : cnt_nxt;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) last_q <= in_i.last;
    if (wave_vld[MAX_WINDOW]) begin
      mn_q <= wave_min[MAX_WINDOW];
      mx_q <= wave_max[MAX_WINDOW];
    end
    if (load) begin
      out_full_q <= full;
      out_min_q  <= full ? mn_q : '0;
      out_max_q  <= full ? mx_q : '0;
      out_hit_q  <= hit;
      out_cnt_q  <= cnt_nxt;
      out_eor_q  <= last_q;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.window_full = out_full_q;
  assign out_o.window_min  = out_min_q;
  assign out_o.window_max  = out_max_q;
  assign out_o.hit         = out_hit_q;
  assign out_o.hit_count   = out_cnt_q;
  assign out_o.end_of_run  = out_eor_q;

endmodule

// ===== src/swrc_chk.sv =====
// port-level checks for the range counter, bound to the top level
module swrc_chk #(
  parameter int unsigned SAMPLE_BITS = swrc_pkg::DEF_SAMPLE_BITS
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic                            window_full_i,
  input logic signed [SAMPLE_BITS-1:0]   window_min_i,
  input logic signed [SAMPLE_BITS-1:0]   window_max_i,
  input logic                            hit_i,
  input logic [swrc_pkg::COUNT_BITS-1:0] hit_count_i
);

  // a pending result is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped before it was taken");

  // one sample in work at a time
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("sample taken while another is in work");

  // a hit needs a full window
  a_hit_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && hit_i |-> window_full_i)
    else $error("hit reported on a window that is not full");

  // unfilled windows report zeros
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !window_full_i |-> (window_min_i == '0) && (window_max_i == '0) && !hit_i)
    else $error("non-zero min or max on a window that is not full");

  // a hit is always counted
  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && hit_i |-> (hit_count_i != '0))
    else $error("hit reported with a zero count");

endmodule

bind sliding_window_range_counter swrc_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_swrc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .window_full_i (out_o.window_full),
  .window_min_i  (out_o.window_min),
  .window_max_i  (out_o.window_max),
  .hit_i         (out_o.hit),
  .hit_count_i   (out_o.hit_count)
);

// ===== tb/sv/tb_top.sv =====
// self-checking bench for the sliding window range counter
module tb_top;

  localparam int unsigned MAX_WIN      = swrc_pkg::DEF_MAX_WINDOW;
  localparam int unsigned SMP_W        = swrc_pkg::DEF_SAMPLE_BITS;
  // one sample in flight; its result follows once the wave has crossed the cell chain
  localparam int unsigned LATENCY      = MAX_WIN + 2;
  // cycles without any beat before the run is declared hung
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned ITEM_TARGET  = 1250;
  // long receiver hold-off so the block backs up into its input
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned HOLD_AT_BEAT = 200;

  typedef logic signed [SMP_W-1:0] sample_t;

  localparam sample_t SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam sample_t SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

  typedef struct packed {
    logic                            full;
    sample_t                         lo;
    sample_t                         hi;
    logic                            hit;
    logic [swrc_pkg::COUNT_BITS-1:0] count;
    logic                            eor;
  } window_result_t;

  localparam window_result_t NO_WANT = '0;

  // directed table rows: either a sample beat or a window size write
  typedef enum logic {ROW_BEAT, ROW_SIZE} row_kind_e;

  typedef struct {
    row_kind_e                     kind;
    logic [swrc_pkg::CFG_BITS-1:0] size;
    sample_t                       sample;
    logic                          last;
    bit                            typed;
    window_result_t                want;
  } stim_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [swrc_pkg::CFG_BITS-1:0] cfg_wdata_i;

  swrc_in_if  #(.SAMPLE_BITS(SMP_W)) smp_if ();
  swrc_out_if #(.SAMPLE_BITS(SMP_W)) res_if ();

  sliding_window_range_counter #(
    .MAX_WINDOW (MAX_WIN),
    .SAMPLE_BITS(SMP_W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (smp_if),
    .out_o      (res_if)
  );

  // shadow copy of the block state, newest sample at index 0
  sample_t                         held_smp [MAX_WIN];
  int unsigned                     fill_lvl;
  logic [swrc_pkg::COUNT_BITS-1:0] hit_tally;
  logic [swrc_pkg::CFG_BITS-1:0]   size_reg;

  window_result_t      window_results_q [$];
  stim_row_t           directed_plan [$];

  int unsigned beats_sent;
  int unsigned results_seen;
  int unsigned hits_seen;
  int unsigned sizes_tried;
  int unsigned fail_count;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned hold_left;
  bit          hold_done;

  // clock, 8 units per period
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // size register as the block reads it: zero acts as one, oversize clips
  function automatic int unsigned eff_size(input logic [swrc_pkg::CFG_BITS-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_WIN) return MAX_WIN;
    return v;
  endfunction

  function automatic void clear_window();
    foreach (held_smp[k]) held_smp[k] = '0;
    fill_lvl  = 0;
    hit_tally = '0;
  endfunction

  // shift in one sample and work out min, max, hit and running count
  function automatic window_result_t step_window(input sample_t s, input logic l);
    window_result_t r;
    int unsigned    w;
    sample_t        lo;
    sample_t        hi;
    r = '0;
    w = eff_size(size_reg);
    for (int k = MAX_WIN - 1; k > 0; k--) held_smp[k] = held_smp[k-1];
    held_smp[0] = s;
    if (fill_lvl < MAX_WIN) fill_lvl++;
    // not full yet: min, max and hit stay at zero
    if (fill_lvl >= w) begin
      lo = held_smp[0];
      hi = held_smp[0];
      for (int k = 1; k < w; k++) begin
        if (held_smp[k] < lo) lo = held_smp[k];
        if (held_smp[k] > hi) hi = held_smp[k];
      end
      r.full = 1'b1;
      r.lo   = lo;
      r.hi   = hi;
      // span taken wide so the extremes cannot wrap
      if ((longint'(hi) - longint'(lo)) == longint'(w) - 1) begin
        r.hit = 1'b1;
        // counter sticks at its top value
        if (hit_tally != '1) hit_tally++;
      end
    end
    r.count = hit_tally;
    r.eor   = l;
    // end of sequence wipes window, fill level and count
    if (l) clear_window();
    return r;
  endfunction

  function automatic window_result_t want_of(input logic full, input sample_t lo,
                                             input sample_t hi, input logic hit,
                                             input int unsigned cnt, input logic eor);
    window_result_t r;
    r.full  = full;
    r.lo    = lo;
    r.hi    = hi;
    r.hit   = hit;
    r.count = cnt;
    r.eor   = eor;
    return r;
  endfunction

  // idling schedule: sender light and receiver heavy, then swapped, then none
  function automatic void update_idling();
    if (beats_sent < ITEM_TARGET / 3) begin
      src_idle_pct = 27;
      snk_idle_pct = 56;
    end else if (beats_sent < 2 * ITEM_TARGET / 3) begin
      src_idle_pct = 56;
      snk_idle_pct = 27;
    end else begin
      src_idle_pct = 0;
      snk_idle_pct = 0;
    end
  endfunction

  // offer one beat, possibly after random gaps, and log its expectation once taken
  task automatic send_beat(input sample_t s, input logic l, input bit typed,
                           input window_result_t want);
    window_result_t pred;
    update_idling();
    while ($urandom_range(0, 99) < src_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= s;
    smp_if.last   <= l;
    do @(posedge clk_i); while (!smp_if.ready);
    // predictor always advances; typed rows override what is expected
    pred = step_window(s, l);
    window_results_q.push_back(typed ? want : pred);
    beats_sent++;
  endtask

  // drop valid and let every outstanding result come back
  task automatic wait_drained();
    smp_if.valid <= 1'b0;
    while (window_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [swrc_pkg::CFG_BITS-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    size_reg     = v;
    sizes_tried++;
  endtask

  // a few sequences at one window size; mostly tight value bands so hits happen
  task automatic run_size_phase(input logic [swrc_pkg::CFG_BITS-1:0] size_val);
    int unsigned w;
    int unsigned len;
    int unsigned pick;
    int unsigned seqs;
    sample_t     base;
    sample_t     s;
    bit          open_end;
    wait_drained();
    write_size(size_val);
    w    = eff_size(size_val);
    seqs = $urandom_range(2, 4);
    for (int q = 0; q < seqs; q++) begin
      len  = $urandom_range(1, w + w / 2 + 4);
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 7))
        0:       base = SMP_MAX - sample_t'(w - 1);
        1:       base = SMP_MIN;
        default: base = $urandom;
      endcase
      // sometimes leave the last sequence open so the next size lands mid-sequence
      open_end = (q == seqs - 1) && ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        if (pick < 70) begin
          s = base + sample_t'($urandom_range(0, w - 1));
        end else if (pick < 85) begin
          // band one too wide, with the odd wild sample
          if ($urandom_range(0, 15) == 0) s = $urandom;
          else s = base + sample_t'($urandom_range(0, w));
        end else begin
          s = $urandom;
        end
        send_beat(s, (i == len - 1) && !open_end, 1'b0, NO_WANT);
      end
    end
  endtask

  task automatic check_result(input window_result_t got);
    window_result_t exp_r;
    if (window_results_q.size() == 0) begin
      $error("result beat with nothing expected");
      fail_count++;
      return;
    end
    exp_r = window_results_q.pop_front();
    results_seen++;
    if (got.hit) hits_seen++;
    if (got.full !== exp_r.full) begin
      $error("window_full expected %0d got %0d", exp_r.full, got.full);
      fail_count++;
    end
    if (got.lo !== exp_r.lo) begin
      $error("window_min expected %0d got %0d", exp_r.lo, got.lo);
      fail_count++;
    end
    if (got.hi !== exp_r.hi) begin
      $error("window_max expected %0d got %0d", exp_r.hi, got.hi);
      fail_count++;
    end
    if (got.hit !== exp_r.hit) begin
      $error("hit expected %0d got %0d", exp_r.hit, got.hit);
      fail_count++;
    end
    if (got.count !== exp_r.count) begin
      $error("hit_count expected %0d got %0d", exp_r.count, got.count);
      fail_count++;
    end
    if (got.eor !== exp_r.eor) begin
      $error("end_of_run expected %0d got %0d", exp_r.eor, got.eor);
      fail_count++;
    end
  endtask

  // receiver: check the beat taken at this edge, then pick next ready
  initial begin
    window_result_t got;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        got.full  = res_if.window_full;
        got.lo    = res_if.window_min;
        got.hi    = res_if.window_max;
        got.hit   = res_if.hit;
        got.count = res_if.hit_count;
        got.eor   = res_if.end_of_run;
        check_result(got);
      end
      if (!hold_done && beats_sent >= HOLD_AT_BEAT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // stimulus: reset, directed table, then random phases over many window sizes
  initial begin
    logic [swrc_pkg::CFG_BITS-1:0] rnd_size;
    rst_ni         = 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    smp_if.valid  <= 1'b0;
    smp_if.sample <= '0;
    smp_if.last   <= 1'b0;
    beats_sent     = 0;
    results_seen   = 0;
    hits_seen      = 0;
    sizes_tried    = 0;
    fail_count     = 0;
    hold_left      = 0;
    hold_done      = 1'b0;
    src_idle_pct   = 0;
    snk_idle_pct   = 0;
    size_reg       = swrc_pkg::WSIZE_RESET;
    clear_window();

    directed_plan = '{
      // size one straight after reset: every sample hits, extremes included
      '{ROW_BEAT, '0, '0,      1'b0, 1'b1, want_of(1, '0, '0, 1, 1, 0)},
      '{ROW_BEAT, '0, SMP_MAX, 1'b0, 1'b1, want_of(1, SMP_MAX, SMP_MAX, 1, 2, 0)},
      '{ROW_BEAT, '0, SMP_MIN, 1'b1, 1'b1, want_of(1, SMP_MIN, SMP_MIN, 1, 3, 1)},
      // size zero behaves as one
      '{ROW_SIZE, 7'd0, '0, 1'b0, 1'b0, NO_WANT},
      '{ROW_BEAT, '0, -1,      1'b1, 1'b1, want_of(1, -1, -1, 1, 1, 1)},
      // size two: not full, hit, miss, full signed span
      '{ROW_SIZE, 7'd2, '0, 1'b0, 1'b0, NO_WANT},
      '{ROW_BEAT, '0, 5,       1'b0, 1'b1, want_of(0, '0, '0, 0, 0, 0)},
      '{ROW_BEAT, '0, 6,       1'b0, 1'b1, want_of(1, 5, 6, 1, 1, 0)},
      '{ROW_BEAT, '0, 8,       1'b0, 1'b1, want_of(1, 6, 8, 0, 1, 0)},
      '{ROW_BEAT, '0, SMP_MAX, 1'b0, 1'b1, want_of(1, 8, SMP_MAX, 0, 1, 0)},
      '{ROW_BEAT, '0, SMP_MIN, 1'b1, 1'b1, want_of(1, SMP_MIN, SMP_MAX, 0, 1, 1)},
      // size three, then oversize and a shrink in the middle of one sequence
      '{ROW_SIZE, 7'd3, '0, 1'b0, 1'b0, NO_WANT},
      '{ROW_BEAT, '0, 10,      1'b0, 1'b1, want_of(0, '0, '0, 0, 0, 0)},
      '{ROW_BEAT, '0, 12,      1'b0, 1'b1, want_of(0, '0, '0, 0, 0, 0)},
      '{ROW_BEAT, '0, 11,      1'b0, 1'b1, want_of(1, 10, 12, 1, 1, 0)},
      '{ROW_SIZE, 7'd65, '0, 1'b0, 1'b0, NO_WANT},
      '{ROW_BEAT, '0, 13,      1'b0, 1'b1, want_of(0, '0, '0, 0, 1, 0)},
      '{ROW_SIZE, 7'd2, '0, 1'b0, 1'b0, NO_WANT},
      '{ROW_BEAT, '0, 14,      1'b0, 1'b1, want_of(1, 13, 14, 1, 2, 0)},
      '{ROW_BEAT, '0, 14,      1'b1, 1'b1, want_of(1, 14, 14, 0, 2, 1)},
      // alternating bit patterns, left to the predictor
      '{ROW_SIZE, 7'd1, '0, 1'b0, 1'b0, NO_WANT},
      '{ROW_BEAT, '0, 32'sh55555555, 1'b0, 1'b0, NO_WANT},
      '{ROW_BEAT, '0, 32'shAAAAAAAA, 1'b1, 1'b0, NO_WANT}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_SIZE) begin
        wait_drained();
        write_size(directed_plan[i].size);
      end else begin
        send_beat(directed_plan[i].sample, directed_plan[i].last,
                  directed_plan[i].typed, directed_plan[i].want);
      end
    end

    // fixed sweep of sizes with the register extremes, then random ones
    run_size_phase(7'd1);
    run_size_phase(7'd2);
    run_size_phase(7'd3);
    run_size_phase(7'd4);
    run_size_phase(7'd64);
    run_size_phase(7'd5);
    run_size_phase(7'd127);
    run_size_phase(7'd8);
    run_size_phase(7'd0);
    run_size_phase(7'd16);
    run_size_phase(7'd65);
    run_size_phase(7'd31);
    run_size_phase(7'd63);
    while (beats_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) rnd_size = $urandom_range(0, 127);
      else rnd_size = $urandom_range(1, 12);
      run_size_phase(rnd_size);
    end

    // drain, then give any stray beat time to show up
    wait_drained();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (window_results_q.size() != 0) begin
      $error("%0d results never arrived", window_results_q.size());
      fail_count++;
    end

    $display("tb_top: %0d samples sent, %0d results checked, %0d with a hit",
             beats_sent, results_seen, hits_seen);
    $display("tb_top: %0d window size writes, receiver held off for %0d cycles once",
             sizes_tried, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/swrc_pkg.sv
src/swrc_in_if.sv
src/swrc_out_if.sv
src/swrc_cell.sv
src/sliding_window_range_counter.sv
src/swrc_chk.sv
tb/sv/tb_top.sv
